// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define LPFT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true.
`define LPFT_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `LPFT_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/core/lpft_pkg.sv -----
`timescale 1ns / 1ps
package lpft_pkg;

  localparam int MaxTablePower = 10;
  localparam int SlotIdxW      = 10;
  localparam int CfgW          = 4;
  localparam int StatusW       = 2;
  localparam int OpW           = 2;

  localparam logic [CfgW-1:0] ResetTablePower = 4'd10;

  localparam logic [OpW-1:0] OpLookup = 2'd0;
  localparam logic [OpW-1:0] OpInsert = 2'd1;
  localparam logic [OpW-1:0] OpDelete = 2'd2;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] mtime;
    logic [31:0] length;
    logic [47:0] start;
  } slot_t;

endpackage

// ----- rtl/core/lpft_slot_ram.sv -----
`timescale 1ns / 1ps
module lpft_slot_ram #(
  parameter int MAX_TABLE_POWER = lpft_pkg::MaxTablePower
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [MAX_TABLE_POWER-1:0] waddr_i,
  input  lpft_pkg::slot_t            wdata_i,
  input  logic [MAX_TABLE_POWER-1:0] raddr_i,
  output lpft_pkg::slot_t            rdata_o
);
  import lpft_pkg::*;

  localparam int Depth = 1 << MAX_TABLE_POWER;

  slot_t mem [Depth];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lpft_probe_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lpft_probe_ctrl #(
  parameter int MAX_TABLE_POWER = lpft_pkg::MaxTablePower
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lpft_pkg::OpW-1:0]        op_i,
  input  logic [MAX_TABLE_POWER-1:0]      home_i,
  input  logic [MAX_TABLE_POWER-1:0]      mask_i,
  input  logic [31:0]                     key_hash_i,
  input  logic [31:0]                     stamp_time_i,
  input  logic [31:0]                     new_size_i,
  input  logic [47:0]                     end_position_i,
  output logic                            we_o,
  output logic [MAX_TABLE_POWER-1:0]      waddr_o,
  output lpft_pkg::slot_t                 wdata_o,
  output logic [MAX_TABLE_POWER-1:0]      raddr_o,
  input  lpft_pkg::slot_t                 rdata_i,
  output logic                            done_o,
  output logic [lpft_pkg::StatusW-1:0]    status_o,
  output logic [lpft_pkg::SlotIdxW-1:0]   slot_index_o,
  output logic [31:0]                     slot_time_o,
  output logic [31:0]                     slot_size_o,
  output logic [47:0]                     slot_first_block_o
);
  import lpft_pkg::*;

  localparam int P = MAX_TABLE_POWER;
  localparam logic [P-1:0] IdxOne = P'(1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StClear = 2'd1;
  localparam logic [1:0] StProbe = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [P-1:0]       idx_q, idx_d;
  logic               first_q, first_d;
  logic [OpW-1:0]     op_q;
  logic [31:0]        hash_q, stamp_q, size_q;
  logic [47:0]        endp_q;
  logic               done_q, done_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [P-1:0]       sidx_q, sidx_d;
  slot_t              res_q, res_d;

  logic               accept;
  logic               slot_empty, hash_hit, last_slot;
  logic [P-1:0]       idx_next;

  assign accept     = start_i && (state_q == StIdle);
  assign slot_empty = (rdata_i.hash == '0) && (rdata_i.mtime == '0);
  assign hash_hit   = !slot_empty && (rdata_i.hash == hash_q);
  assign last_slot  = (idx_q == mask_i);
  assign idx_next   = idx_q + IdxOne;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    first_d  = first_q;
    done_d   = 1'b0;
    status_d = status_q;
    sidx_d   = sidx_q;
    res_d    = res_q;
    we_o     = 1'b0;
    wdata_o  = '0;
    raddr_o  = idx_next;
    case (state_q)
      StIdle: begin
        raddr_o = home_i;
        if (start_i) begin
          idx_d   = home_i;
          first_d = 1'b1;
          state_d = StProbe;
        end
      end
      StClear: begin
        we_o  = 1'b1;
        idx_d = idx_next;
        if (&idx_q) begin
          state_d = StIdle;
        end
      end
      StProbe: begin
        first_d = 1'b0;
        idx_d   = idx_next;
        if (op_q == OpInsert) begin
          if (slot_empty) begin
            we_o          = 1'b1;
            wdata_o.hash  = hash_q;
            wdata_o.mtime = stamp_q;
            wdata_o.length = size_q;
            // keep a leftover first block from an earlier tenant
            wdata_o.start = (rdata_i.start == '0) ? endp_q : rdata_i.start;
            done_d   = 1'b1;
            status_d = StatusOk;
            sidx_d   = idx_q;
            res_d    = wdata_o;
          end else if (last_slot) begin
            done_d   = 1'b1;
            status_d = StatusFull;
            sidx_d   = '0;
            res_d    = '0;
          end
        end else begin
          if (first_q && slot_empty) begin
            done_d   = 1'b1;
            status_d = StatusNotFound;
            sidx_d   = '0;
            res_d    = '0;
          end else if (hash_hit) begin
            done_d   = 1'b1;
            status_d = StatusOk;
            sidx_d   = idx_q;
            res_d    = rdata_i;
            if (op_q == OpDelete) begin
              we_o           = 1'b1;
              wdata_o.length = rdata_i.length;
              wdata_o.start  = rdata_i.start;
              res_d          = wdata_o;
            end
          end else if (last_slot) begin
            done_d   = 1'b1;
            status_d = StatusNotFound;
            sidx_d   = '0;
            res_d    = '0;
          end
        end
        if (done_d) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q   <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      hash_q  <= key_hash_i;
      stamp_q <= stamp_time_i;
      size_q  <= new_size_i;
      endp_q  <= end_position_i;
    end
    status_q <= status_d;
    sidx_q   <= sidx_d;
    res_q    <= res_d;
  end

  assign busy_o             = (state_q != StIdle);
  assign waddr_o            = idx_q;
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign slot_index_o       = SlotIdxW'(sidx_q);
  assign slot_time_o        = res_q.mtime;
  assign slot_size_o        = res_q.length;
  assign slot_first_block_o = res_q.start;

  // a new word is taken only in idle and must then probe, so strobes never abut
  `LPFT_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "result strobe lasted two cycles")
  `LPFT_ASSERT_NEVER(a_idle_write, clk_i, rst_ni, we_o && (state_q == StIdle), "table written while idle")
  `LPFT_ASSERT(a_miss_zero, clk_i, rst_ni, (done_q && (status_q != StatusOk)) |-> ((sidx_q == '0) && (res_q == '0)), "miss word carries slot data")
  `LPFT_ASSERT(a_clear_busy, clk_i, rst_ni, (state_q == StClear) |-> (busy_o && we_o && !done_q), "clearing pass not exclusive")

endmodule

// ----- rtl/core/linear_probe_file_table_core.sv -----
`timescale 1ns / 1ps
// A word probing n slots (1 to 2^P, P the saturated table power) strobes done_o from a
// register once its last slot is read; busy_o is high while it probes, one slot read per cycle.
// One word at a time, taken only while busy_o is low; the slot memory has a single read port.
// Results cannot be stalled: done_o is a one-cycle strobe.
// Reset: table power returns to 10 and a clearing pass writes zero to all
// 2^MAX_TABLE_POWER slots with busy_o high; config writes always taken.
module linear_probe_file_table_core #(
  parameter int MAX_TABLE_POWER = lpft_pkg::MaxTablePower
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpft_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [lpft_pkg::OpW-1:0]      op_i,
  input  logic [31:0]                   tag_index_i,
  input  logic [31:0]                   key_hash_i,
  input  logic [31:0]                   stamp_time_i,
  input  logic [31:0]                   new_size_i,
  input  logic [47:0]                   end_position_i,
  output logic                          done_o,
  output logic [lpft_pkg::StatusW-1:0]  status_o,
  output logic [lpft_pkg::SlotIdxW-1:0] slot_index_o,
  output logic [31:0]                   slot_time_o,
  output logic [31:0]                   slot_size_o,
  output logic [47:0]                   slot_first_block_o
);
  import lpft_pkg::*;

  localparam int P = MAX_TABLE_POWER;
  localparam logic [CfgW:0] MaxPow = (CfgW+1)'(MAX_TABLE_POWER);

  logic [CfgW-1:0] power_q;
  logic [CfgW:0]   power_eff;
  logic [P-1:0]    mask, home;

  logic            we;
  logic [P-1:0]    waddr, raddr;
  slot_t           wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= ResetTablePower;
    end else if (cfg_valid_i) begin
      power_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign power_eff   = ({1'b0, power_q} > MaxPow) ? MaxPow : {1'b0, power_q};

  for (genvar k = 0; k < P; k++) begin : g_mask
    assign mask[k] = ((CfgW+1)'(k) < power_eff);
  end

  assign home = tag_index_i[P-1:0] & mask;

  lpft_slot_ram #(
    .MAX_TABLE_POWER(MAX_TABLE_POWER)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  lpft_probe_ctrl #(
    .MAX_TABLE_POWER(MAX_TABLE_POWER)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .op_i              (op_i),
    .home_i            (home),
    .mask_i            (mask),
    .key_hash_i        (key_hash_i),
    .stamp_time_i      (stamp_time_i),
    .new_size_i        (new_size_i),
    .end_position_i    (end_position_i),
    .we_o              (we),
    .waddr_o           (waddr),
    .wdata_o           (wdata),
    .raddr_o           (raddr),
    .rdata_i           (rdata),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .slot_time_o       (slot_time_o),
    .slot_size_o       (slot_size_o),
    .slot_first_block_o(slot_first_block_o)
  );

endmodule

// ----- verif/tb_linear_probe_file_table_core.sv -----
`timescale 1ns / 1ps
module tb_linear_probe_file_table_core;
  import lpft_pkg::*;

  localparam int unsigned TableDepth    = 1 << MaxTablePower;
  localparam int unsigned WatchdogLimit = 8000;
  localparam int unsigned DrainCycles   = 1100;
  // op 3 is not decoded by the block and falls through to a lookup
  localparam logic [OpW-1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [31:0]    tag;
    logic [31:0]    hash;
    logic [31:0]    stamp;
    logic [31:0]    fsize;
    logic [47:0]    endp;
  } file_req_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [SlotIdxW-1:0] slot;
    logic [31:0]         mtime;
    logic [31:0]         fsize;
    logic [47:0]         first_block;
  } slot_reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [OpW-1:0]      op_i = '0;
  logic [31:0]         tag_index_i = '0;
  logic [31:0]         key_hash_i = '0;
  logic [31:0]         stamp_time_i = '0;
  logic [31:0]         new_size_i = '0;
  logic [47:0]         end_position_i = '0;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [SlotIdxW-1:0] slot_index_o;
  logic [31:0]         slot_time_o;
  logic [31:0]         slot_size_o;
  logic [47:0]         slot_first_block_o;

  linear_probe_file_table_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .op_i              (op_i),
    .tag_index_i       (tag_index_i),
    .key_hash_i        (key_hash_i),
    .stamp_time_i      (stamp_time_i),
    .new_size_i        (new_size_i),
    .end_position_i    (end_position_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .slot_time_o       (slot_time_o),
    .slot_size_o       (slot_size_o),
    .slot_first_block_o(slot_first_block_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the table and its size register
  slot_t           file_slot [TableDepth];
  logic [CfgW-1:0] table_power = ResetTablePower;

  file_req_t   words_to_send [$];
  file_req_t   known_files [$];
  slot_reply_t replies_due [$];
  file_req_t   next_word;
  slot_reply_t want;
  bit          word_taken = 1'b0;
  bit          idling_on = 1'b1;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;

  function automatic bit slot_empty(int unsigned i);
    return file_slot[i].hash == '0 && file_slot[i].mtime == '0;
  endfunction

  function automatic slot_reply_t probe_file_table(logic [OpW-1:0] op, logic [31:0] tag,
                                                   logic [31:0] hash, logic [31:0] stamp,
                                                   logic [31:0] fsize, logic [47:0] endp);
    int unsigned pw, span, home, idx;
    bit          hit;
    slot_reply_t r;
    pw   = (table_power > MaxTablePower) ? MaxTablePower : table_power;
    span = 1 << pw;
    home = tag & (span - 1);
    hit  = 1'b0;
    idx  = 0;
    r    = '0;
    r.status = StatusNotFound;
    if (op == OpInsert) begin
      r.status = StatusFull;
      for (int unsigned i = home; i < span; i++) begin
        if (!hit && slot_empty(i)) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (hit) begin
        file_slot[idx].hash   = hash;
        file_slot[idx].mtime  = stamp;
        file_slot[idx].length = fsize;
        // a freed slot keeps its old first block
        if (file_slot[idx].start == '0) file_slot[idx].start = endp;
      end
    end else if (!slot_empty(home)) begin
      for (int unsigned i = home; i < span; i++) begin
        if (!hit && !slot_empty(i) && file_slot[i].hash == hash) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (hit && op == OpDelete) begin
        file_slot[idx].hash  = '0;
        file_slot[idx].mtime = '0;
      end
    end
    if (hit) begin
      r.status      = StatusOk;
      r.slot        = idx[SlotIdxW-1:0];
      r.mtime       = file_slot[idx].mtime;
      r.fsize       = file_slot[idx].length;
      r.first_block = file_slot[idx].start;
    end
    return r;
  endfunction

  // driver: holds a word until it is taken, random gaps between words while idling_on is set
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !word_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (words_to_send.size() != 0 && idling_on && $urandom_range(0, 6) == 0) begin
        gap_left = $urandom_range(0, 11);
        start_i <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        next_word = words_to_send.pop_front();
        op_i           <= next_word.op;
        tag_index_i    <= next_word.tag;
        key_hash_i     <= next_word.hash;
        stamp_time_i   <= next_word.stamp;
        new_size_i     <= next_word.fsize;
        end_position_i <= next_word.endp;
        start_i        <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predicts on accept, checks on done, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken <= start_i && !busy_o;
      if (cfg_valid_i && cfg_ready_o) table_power = cfg_data_i;
      if (start_i && !busy_o)
        replies_due.push_back(probe_file_table(op_i, tag_index_i, key_hash_i, stamp_time_i,
                                               new_size_i, end_position_i));
      if (done_o) begin
        if (replies_due.size() == 0) begin
          $error("result word with no request pending");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_count++;
          end
          if (slot_index_o !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, slot_index_o);
            fail_count++;
          end
          if (slot_time_o !== want.mtime) begin
            $error("slot_time: expected %0h, got %0h", want.mtime, slot_time_o);
            fail_count++;
          end
          if (slot_size_o !== want.fsize) begin
            $error("slot_size: expected %0h, got %0h", want.fsize, slot_size_o);
            fail_count++;
          end
          if (slot_first_block_o !== want.first_block) begin
            $error("slot_first_block: expected %0h, got %0h", want.first_block,
                   slot_first_block_o);
            fail_count++;
          end
        end
      end
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("linear_probe_file_table_core: mismatch");
        $finish;
      end
    end
  end

  task automatic queue_word(logic [OpW-1:0] op, logic [31:0] tag, logic [31:0] hash,
                            logic [31:0] stamp, logic [31:0] fsize, logic [47:0] endp);
    file_req_t w;
    w = '{op: op, tag: tag, hash: hash, stamp: stamp, fsize: fsize, endp: endp};
    words_to_send.push_back(w);
  endtask

  // inserts, and lookups and deletes mostly of files inserted earlier, some random misses
  task automatic queue_random_words(int unsigned count);
    file_req_t   w;
    int unsigned pick;
    repeat (count) begin
      w.tag   = $urandom;
      w.hash  = $urandom;
      w.stamp = $urandom;
      w.fsize = $urandom;
      w.endp  = {16'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 36) w.op = OpInsert;
      else if (pick < 66) w.op = OpLookup;
      else if (pick < 95) w.op = OpDelete;
      else w.op = OpSpare;
      if ($urandom_range(0, 9) == 0) w.hash = '0;
      if ($urandom_range(0, 9) == 0) w.stamp = '0;
      if ($urandom_range(0, 15) == 0) w.endp = '0;
      if (w.op == OpInsert) begin
        known_files.push_back(w);
        if (known_files.size() > 48) void'(known_files.pop_front());
      end else if (known_files.size() != 0 && $urandom_range(0, 3) != 0) begin
        pick   = $urandom_range(0, known_files.size() - 1);
        w.tag  = known_files[pick].tag;
        w.hash = known_files[pick].hash;
      end
      words_to_send.push_back(w);
    end
  endtask

  // sampled on the rising edge, where start_i is settled after the driver's update
  task automatic wait_drained();
    do @(posedge clk_i);
    while (words_to_send.size() != 0 || replies_due.size() != 0 || start_i || busy_o);
  endtask

  task automatic write_table_power(logic [CfgW-1:0] pw);
    @(negedge clk_i);
    cfg_data_i  <= pw;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [CfgW-1:0] pw, int unsigned count);
    write_table_power(pw);
    queue_random_words(count);
    wait_drained();
  endtask

  initial begin
    for (int unsigned i = 0; i < TableDepth; i++) file_slot[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full-size table after reset: top slot, full, reuse of freed block, empty claims
    queue_word(OpLookup, 32'hFFFF_FFFF, 32'h1234_5678, '0, '0, '0);
    queue_word(OpInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               48'hFFFF_FFFF_FFFF);
    queue_word(OpInsert, 32'h0000_03FF, 32'h0000_0042, 32'h1, 32'h2, 48'h3);
    queue_word(OpLookup, 32'h0000_03FF, 32'hFFFF_FFFF, '0, '0, '0);
    queue_word(OpLookup, 32'h0000_03FF, 32'h0000_0042, '0, '0, '0);
    queue_word(OpDelete, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
    queue_word(OpInsert, 32'hFFFF_FFFF, 32'h0000_0005, '0, 32'h7, 48'h123);
    // zero hash and zero time: slot stays empty after the insert
    queue_word(OpInsert, 32'hFFFF_FC00, '0, '0, 32'h8000_0000, '0);
    queue_word(OpInsert, 32'h0000_0000, 32'h0000_0001, '0, 32'h11, 48'h8000_0000_0000);
    queue_word(OpInsert, 32'h0000_0000, '0, 32'h1, 32'h22, 48'h5555_5555_5555);
    queue_word(OpLookup, 32'h0000_0000, '0, '0, '0, '0);
    queue_word(OpLookup, 32'h0000_0002, 32'h0000_0001, '0, '0, '0);
    queue_word(OpSpare, 32'h0000_0000, 32'h0000_0001, '0, '0, '0);
    queue_word(OpDelete, 32'h0000_0001, 32'h0000_0001, '0, '0, '0);
    queue_word(OpDelete, 32'h0000_0000, '0, '0, '0, '0);
    wait_drained();

    // single-slot table
    write_table_power(4'd0);
    queue_word(OpInsert, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h9, 48'h9);
    queue_word(OpDelete, 32'h8000_0000, 32'h0000_0001, '0, '0, '0);
    queue_word(OpInsert, 32'h7FFF_FFFF, 32'h0BAD_F00D, 32'h3, 32'h4, 48'hAAAA_AAAA_AAAA);
    queue_word(OpInsert, 32'h0000_0001, 32'hCAFE_0001, 32'h3, 32'h4, 48'h1);
    queue_random_words(30);
    wait_drained();

    run_phase(4'd3, 80);
    run_phase(4'd1, 40);
    run_phase(4'd5, 60);
    run_phase(4'd15, 12);
    run_phase(4'd2, 50);
    run_phase(4'd4, 60);
    run_phase(4'd6, 50);
    run_phase(4'd8, 25);
    run_phase(4'd12, 12);
    run_phase(4'd7, 30);
    run_phase(4'd0, 20);
    run_phase(4'd10, 12);
    idling_on = 1'b0;
    run_phase(4'd3, 80);

    repeat (DrainCycles) @(posedge clk_i);
    fail_count += replies_due.size();
    if (fail_count == 0) $display("linear_probe_file_table_core: match");
    else $display("linear_probe_file_table_core: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lpft_pkg.sv
rtl/core/lpft_slot_ram.sv
rtl/core/lpft_probe_ctrl.sv
rtl/core/linear_probe_file_table_core.sv
verif/tb_linear_probe_file_table_core.sv
